>>> rtl/tcpq_pkg.sv
// Package for the two-class priority queue: sizes, codes and shared types.
// No dependencies; imported by the top level.
package tcpq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int TAG_W       = 16;
	localparam int CLASS_W     = 7;
	localparam int IN_DATA_W   = 24;   // tag + class, padded to bytes
	localparam int OUT_DATA_W  = 16;   // served tag
	localparam int OUT_USER_W  = 3;    // status + priority flag

	localparam logic [CLASS_W-1:0] THRESHOLD_RESET = CLASS_W'(60);

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [TAG_W-1:0]   tag_t;
	typedef logic [CLASS_W-1:0] class_t;

	typedef enum logic {
		OP_ENQUEUE = 1'b0,
		OP_SERVE   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_ENQUEUED = 2'd0,
		ST_SERVED   = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_DROPPED  = 2'd3
	} status_t;

	// Wrapping increment of a ring pointer.
	function automatic idx_t ring_next(input idx_t pos);
		if (pos == idx_t'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return pos + idx_t'(1);
	endfunction

endpackage

>>> rtl/tcpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for both tag stores of the queue.
module tcpq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> rtl/two_class_priority_queue.sv
// An accepted request waits in the stage 1 register until the result slot is free,
// and its result is then registered into the output register that drives m_axis.
// One request per cycle unless m_axis stalls; each moves head/tail/count of one ring.
// Tag stores are registered-read RAMs, prefetched at the head pointer each cycle.
// Reset (arst_n low, async): pointers and counts zero, threshold 60, pipeline empty.
// Tag store contents are not cleared; only occupied entries are ever read.
// Depends on tcpq_pkg and tcpq_ram.
module two_class_priority_queue
	import tcpq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration: threshold register
	input  logic                  cfg_wr_en,
	input  logic [CLASS_W-1:0]    cfg_wr_data,   // priority_threshold
	// request stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [15:0] item_tag, [22:16] class_value
	input  logic                  s_axis_tuser,  // [0] operation
	// result stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [15:0] served_tag
	output logic [OUT_USER_W-1:0] m_axis_tuser   // [1:0] status, [2] priority_class
);

	// ---------------------------------------------------------------
	// Threshold register
	// ---------------------------------------------------------------
	class_t thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// ---------------------------------------------------------------
	// Input register (stage 1)
	// ---------------------------------------------------------------
	logic   req_valid_s1;
	op_t    op_s1;
	tag_t   tag_s1;
	class_t class_s1;
	logic   advance;
	logic   out_valid_q;

	// the request in stage 1 moves on when the result slot is free or draining
	assign advance       = req_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !req_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			req_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1    <= op_t'(s_axis_tuser);
			tag_s1   <= s_axis_tdata[TAG_W-1:0];
			class_s1 <= s_axis_tdata[TAG_W +: CLASS_W];
		end
	end

	// ---------------------------------------------------------------
	// Ring pointers and counts
	// ---------------------------------------------------------------
	idx_t n_head_q, n_tail_q, p_head_q, p_tail_q;
	cnt_t n_count_q, p_count_q;
	idx_t n_head_d, p_head_d;

	logic is_enq, is_hi;
	logic n_full, p_full, n_empty, p_empty;
	logic n_push, p_push, n_pop, p_pop;

	assign is_enq  = (op_s1 == OP_ENQUEUE);
	assign is_hi   = (class_s1 >= thr_q);
	assign n_full  = (n_count_q == cnt_t'(QUEUE_DEPTH));
	assign p_full  = (p_count_q == cnt_t'(QUEUE_DEPTH));
	assign n_empty = (n_count_q == '0);
	assign p_empty = (p_count_q == '0);

	// strict priority: normal ring is served only when the priority ring is empty
	assign p_push = advance && is_enq && is_hi && !p_full;
	assign n_push = advance && is_enq && !is_hi && !n_full;
	assign p_pop  = advance && !is_enq && !p_empty;
	assign n_pop  = advance && !is_enq && p_empty && !n_empty;

	assign n_head_d = n_pop ? ring_next(n_head_q) : n_head_q;
	assign p_head_d = p_pop ? ring_next(p_head_q) : p_head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_head_q  <= '0;
			n_tail_q  <= '0;
			n_count_q <= '0;
			p_head_q  <= '0;
			p_tail_q  <= '0;
			p_count_q <= '0;
		end else begin
			n_head_q <= n_head_d;
			p_head_q <= p_head_d;
			if (n_push) begin
				n_tail_q  <= ring_next(n_tail_q);
				n_count_q <= n_count_q + cnt_t'(1);
			end else if (n_pop) begin
				n_count_q <= n_count_q - cnt_t'(1);
			end
			if (p_push) begin
				p_tail_q  <= ring_next(p_tail_q);
				p_count_q <= p_count_q + cnt_t'(1);
			end else if (p_pop) begin
				p_count_q <= p_count_q - cnt_t'(1);
			end
		end
	end

	// ---------------------------------------------------------------
	// Tag stores. Read address is the next head, so the head entry is
	// ready in the following cycle. A write landing on that same address
	// is caught by a one-entry bypass, since the RAM returns old data.
	// ---------------------------------------------------------------
	tag_t n_ram_rd, p_ram_rd;
	tag_t n_byp_data_q, p_byp_data_q;
	logic n_byp_q, p_byp_q;
	tag_t n_head_tag, p_head_tag;

	tcpq_ram #(
		.WIDTH (TAG_W),
		.DEPTH (QUEUE_DEPTH)
	) u_normal_store (
		.clk     (clk),
		.wr_en   (n_push),
		.wr_addr (n_tail_q),
		.wr_data (tag_s1),
		.rd_addr (n_head_d),
		.rd_data (n_ram_rd)
	);

	tcpq_ram #(
		.WIDTH (TAG_W),
		.DEPTH (QUEUE_DEPTH)
	) u_priority_store (
		.clk     (clk),
		.wr_en   (p_push),
		.wr_addr (p_tail_q),
		.wr_data (tag_s1),
		.rd_addr (p_head_d),
		.rd_data (p_ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_byp_q <= 1'b0;
			p_byp_q <= 1'b0;
		end else begin
			n_byp_q <= n_push && (n_tail_q == n_head_d);
			p_byp_q <= p_push && (p_tail_q == p_head_d);
		end
	end

	always_ff @(posedge clk) begin
		n_byp_data_q <= tag_s1;
		p_byp_data_q <= tag_s1;
	end

	assign n_head_tag = n_byp_q ? n_byp_data_q : n_ram_rd;
	assign p_head_tag = p_byp_q ? p_byp_data_q : p_ram_rd;

	// ---------------------------------------------------------------
	// Result
	// ---------------------------------------------------------------
	status_t res_status;
	tag_t    res_tag;
	logic    res_prio;

	always_comb begin
		res_status = ST_EMPTY;
		res_tag    = '0;
		res_prio   = 1'b0;
		unique case (op_s1)
			OP_ENQUEUE: begin
				res_prio   = is_hi;
				res_status = (is_hi ? p_full : n_full) ? ST_DROPPED : ST_ENQUEUED;
			end
			OP_SERVE: begin
				if (!p_empty) begin
					res_status = ST_SERVED;
					res_tag    = p_head_tag;
					res_prio   = 1'b1;
				end else if (!n_empty) begin
					res_status = ST_SERVED;
					res_tag    = n_head_tag;
				end
			end
			default: ;
		endcase
	end

	status_t status_q;
	tag_t    served_q;
	logic    prio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= res_status;
			served_q <= res_tag;
			prio_q   <= res_prio;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = served_q;
	assign m_axis_tuser  = {prio_q, status_q};

endmodule
